// ===== rtl/video_register_port_defines.svh =====
// Assertion macros for the video register port.
// Included by video_register_port, which carries the checks; no other dependencies.
`ifndef VIDEO_REGISTER_PORT_DEFINES_SVH
`define VIDEO_REGISTER_PORT_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that a property holds on every clock edge outside reset.
`define VRP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("video_register_port: property check failed");
// Checks that a condition never holds outside reset.
`define VRP_FORBID(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("video_register_port: forbidden condition seen");
`else
`define VRP_ASSERT(label, prop)
`define VRP_FORBID(label, cond)
`endif
`endif

// ===== rtl/vrp_pkg.sv =====
// Shared types and constants of the video register port.
// No dependencies; used by every module of the block.
package vrp_pkg;

	// Memory sizes and address widths.
	localparam int PAT_AW = 13;
	localparam int NT_AW = 11;
	localparam int PAL_AW = 5;
	localparam int OAM_AW = 8;

	// Command codes.
	localparam logic [1:0] CMD_READ = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	// Register window.
	localparam logic [2:0] REG_CONTROL = 3'd0;
	localparam logic [2:0] REG_MASK = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_VRAM_ADDR = 3'd6;
	localparam logic [2:0] REG_VRAM_DATA = 3'd7;

	// VRAM address map, in the 14-bit space.
	localparam logic [13:0] NT_BASE = 14'h2000;
	localparam logic [13:0] PAL_BASE = 14'h3f00;

	// Address steps for VRAM data accesses.
	localparam logic [15:0] STEP_COLUMN = 16'h0001;
	localparam logic [15:0] STEP_ROW = 16'h0020;

	// Control and mask bits.
	localparam int CTRL_ROW_STEP_BIT = 2;
	localparam int MASK_SHOW_BG_BIT = 3;

	// Input beat.
	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  register_select;
		logic [7:0]  write_data;
		logic [12:0] pattern_address;
		logic [1:0]  status_flags;
	} cmd_beat_t;

	// Result beat.
	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] control_byte;
		logic [7:0] mask_byte;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
	} rsp_beat_t;

	// Write request into the VRAM memories.
	typedef struct packed {
		logic              nt_we;
		logic              pal_we;
		logic              pat_we;
		logic [PAT_AW-1:0] pat_addr;
		logic [7:0]        data;
	} vram_wr_t;

	// Registered read data of the VRAM memories.
	typedef struct packed {
		logic [7:0] pat;
		logic [7:0] nt;
		logic [7:0] pal;
	} vram_rd_t;

endpackage

// ===== rtl/vrp_vram.sv =====
// Pattern, nametable and palette memories of the video register port.
// Depends on vrp_pkg for sizes and the request and read data structs.
module vrp_vram (
	input  logic               clk,
	input  logic [13:0]        addr,
	input  vrp_pkg::vram_wr_t  wr,
	output vrp_pkg::vram_rd_t  rd
);

	logic [7:0] pat_mem [2**vrp_pkg::PAT_AW];
	logic [7:0] nt_mem [2**vrp_pkg::NT_AW];
	logic [7:0] pal_mem [2**vrp_pkg::PAL_AW];
	logic [vrp_pkg::PAL_AW-1:0] pal_idx;

	// Sprite backdrop entries fold onto the background backdrop entries.
	always_comb begin
		pal_idx = addr[vrp_pkg::PAL_AW-1:0];
		if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
			pal_idx[4] = 1'b0;
		end
	end

	// Pattern memory: written by the load command, read at the VRAM address.
	always_ff @(posedge clk) begin
		if (wr.pat_we) begin
			pat_mem[wr.pat_addr] <= wr.data;
		end
		rd.pat <= pat_mem[addr[vrp_pkg::PAT_AW-1:0]];
	end

	// Nametable memory, mirrored over the whole nametable region.
	always_ff @(posedge clk) begin
		if (wr.nt_we) begin
			nt_mem[addr[vrp_pkg::NT_AW-1:0]] <= wr.data;
		end
		rd.nt <= nt_mem[addr[vrp_pkg::NT_AW-1:0]];
	end

	// Palette memory.
	always_ff @(posedge clk) begin
		if (wr.pal_we) begin
			pal_mem[pal_idx] <= wr.data;
		end
		rd.pal <= pal_mem[pal_idx];
	end

endmodule

// ===== rtl/vrp_oam.sv =====
// Sprite attribute memory of the video register port.
// Depends on vrp_pkg for the address width.
module vrp_oam (
	input  logic                       clk,
	input  logic [vrp_pkg::OAM_AW-1:0] addr,
	input  logic                       we,
	input  logic [7:0]                 wdata,
	output logic [7:0]                 rdata
);

	logic [7:0] oam_mem [2**vrp_pkg::OAM_AW];

	// One write and one registered read, both at the OAM address.
	always_ff @(posedge clk) begin
		if (we) begin
			oam_mem[addr] <= wdata;
		end
		rdata <= oam_mem[addr];
	end

endmodule

// ===== rtl/video_register_port.sv =====
// Channel   Direction  Handshake               Beat
// cmd       in         cmd_valid / cmd_stall   cmd_beat (vrp_pkg::cmd_beat_t)
// rsp       out        rsp_valid / rsp_stall   rsp_beat (vrp_pkg::rsp_beat_t)
//
// On each beat the accept edge starts the synchronous memory reads at the current
// VRAM and OAM addresses, and the later update edge applies the update and loads
// the result register. One beat is in work at a time.
// A stalled result holds the next beat in its update cycle until the result is taken.
// Reset clears the registers but item_s1; memories have no reset and need no sweep.
// Depends on vrp_pkg, vrp_vram, vrp_oam and video_register_port_defines.svh.
`include "video_register_port_defines.svh"

module video_register_port (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  vrp_pkg::cmd_beat_t cmd_beat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output vrp_pkg::rsp_beat_t rsp_beat
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t st_q;
	vrp_pkg::cmd_beat_t item_s1;
	vrp_pkg::rsp_beat_t rsp_q;
	logic rsp_valid_q;

	logic [7:0]  control_q;
	logic [7:0]  mask_q;
	logic [7:0]  sprite_addr_q;
	logic [7:0]  scroll_x_q;
	logic [7:0]  scroll_y_q;
	logic [15:0] vram_addr_q;
	logic        second_q;
	logic [7:0]  rbuf_q;

	logic [7:0]  n_control;
	logic [7:0]  n_mask;
	logic [7:0]  n_sprite_addr;
	logic [7:0]  n_scroll_x;
	logic [7:0]  n_scroll_y;
	logic [15:0] n_vram_addr;
	logic        n_second;
	logic [7:0]  n_rbuf;
	logic [7:0]  rdata;

	logic        exec_go;
	logic [13:0] vaddr;
	logic        is_pat;
	logic        is_pal;
	logic [15:0] step;
	logic [7:0]  buf_fill;

	vrp_pkg::vram_wr_t vram_req;
	vrp_pkg::vram_wr_t vram_wr;
	vrp_pkg::vram_rd_t vram_rd;
	logic              oam_req;
	logic              oam_we;
	logic [7:0]        oam_rd;

	assign cmd_stall = (st_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat = rsp_q;
	assign exec_go = (st_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);

	// Address decode of the 14-bit VRAM space.
	assign vaddr = vram_addr_q[13:0];
	assign is_pat = (vaddr < vrp_pkg::NT_BASE);
	assign is_pal = (vaddr >= vrp_pkg::PAL_BASE);
	assign step = control_q[vrp_pkg::CTRL_ROW_STEP_BIT] ? vrp_pkg::STEP_ROW
		: vrp_pkg::STEP_COLUMN;
	// The buffer refills from the byte under the address; palette reads take the
	// nametable byte underneath.
	assign buf_fill = is_pat ? vram_rd.pat : vram_rd.nt;

	vrp_vram u_vram (
		.clk  (clk),
		.addr (vaddr),
		.wr   (vram_wr),
		.rd   (vram_rd)
	);

	vrp_oam u_oam (
		.clk   (clk),
		.addr  (sprite_addr_q),
		.we    (oam_we),
		.wdata (item_s1.write_data),
		.rdata (oam_rd)
	);

	// Update of the register file for the beat in work.
	always_comb begin
		n_control = control_q;
		n_mask = mask_q;
		n_sprite_addr = sprite_addr_q;
		n_scroll_x = scroll_x_q;
		n_scroll_y = scroll_y_q;
		n_vram_addr = vram_addr_q;
		n_second = second_q;
		n_rbuf = rbuf_q;
		rdata = 8'h00;
		vram_req = '0;
		vram_req.data = item_s1.write_data;
		vram_req.pat_addr = item_s1.pattern_address;
		oam_req = 1'b0;
		case (item_s1.command)
			vrp_pkg::CMD_READ: begin
				unique case (item_s1.register_select)
					vrp_pkg::REG_STATUS: begin
						rdata = {item_s1.status_flags, 6'b000000};
						n_second = 1'b0;
					end
					vrp_pkg::REG_OAM_DATA: begin
						rdata = oam_rd;
					end
					vrp_pkg::REG_VRAM_DATA: begin
						rdata = is_pal ? vram_rd.pal : rbuf_q;
						n_rbuf = buf_fill;
						n_vram_addr = vram_addr_q + step;
					end
					default: begin
					end
				endcase
			end
			vrp_pkg::CMD_WRITE: begin
				unique case (item_s1.register_select)
					vrp_pkg::REG_CONTROL: begin
						// With the background off the nametable select bits hold.
						if (mask_q[vrp_pkg::MASK_SHOW_BG_BIT]) begin
							n_control = item_s1.write_data;
						end else begin
							n_control = {item_s1.write_data[7:2], control_q[1:0]};
						end
					end
					vrp_pkg::REG_MASK: begin
						n_mask = item_s1.write_data;
					end
					vrp_pkg::REG_OAM_ADDR: begin
						n_sprite_addr = item_s1.write_data;
					end
					vrp_pkg::REG_OAM_DATA: begin
						oam_req = 1'b1;
						n_sprite_addr = sprite_addr_q + 8'd1;
					end
					vrp_pkg::REG_SCROLL: begin
						if (second_q) begin
							n_scroll_y = item_s1.write_data;
						end else begin
							n_scroll_x = item_s1.write_data;
						end
						n_second = !second_q;
					end
					vrp_pkg::REG_VRAM_ADDR: begin
						if (second_q) begin
							n_vram_addr = {vram_addr_q[15:8], item_s1.write_data};
						end else begin
							n_vram_addr = {item_s1.write_data, vram_addr_q[7:0]};
						end
						n_second = !second_q;
					end
					vrp_pkg::REG_VRAM_DATA: begin
						// Pattern memory is read-only from the register window.
						vram_req.nt_we = !is_pat && !is_pal;
						vram_req.pal_we = is_pal;
						n_vram_addr = vram_addr_q + step;
					end
					default: begin
					end
				endcase
			end
			vrp_pkg::CMD_LOAD: begin
				vram_req.pat_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Memory writes land only on the update edge.
	always_comb begin
		vram_wr = vram_req;
		vram_wr.nt_we = vram_req.nt_we && exec_go;
		vram_wr.pal_we = vram_req.pal_we && exec_go;
		vram_wr.pat_we = vram_req.pat_we && exec_go;
	end
	assign oam_we = oam_req && exec_go;

	// Accepted beat.
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd_beat;
		end
	end

	// Sequencer, register file and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			control_q <= '0;
			mask_q <= '0;
			sprite_addr_q <= '0;
			scroll_x_q <= '0;
			scroll_y_q <= '0;
			vram_addr_q <= '0;
			second_q <= 1'b0;
			rbuf_q <= '0;
		end else begin
			// A new result fills the register; otherwise a taken result empties it.
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						st_q <= S_IDLE;
						control_q <= n_control;
						mask_q <= n_mask;
						sprite_addr_q <= n_sprite_addr;
						scroll_x_q <= n_scroll_x;
						scroll_y_q <= n_scroll_y;
						vram_addr_q <= n_vram_addr;
						second_q <= n_second;
						rbuf_q <= n_rbuf;
						rsp_q.read_data <= rdata;
						rsp_q.control_byte <= n_control;
						rsp_q.mask_byte <= n_mask;
						rsp_q.scroll_x <= n_scroll_x;
						rsp_q.scroll_y <= n_scroll_y;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted beat always moves into its update cycle.
	`VRP_ASSERT(a_accept_starts_exec, (cmd_valid && !cmd_stall) |=> (st_q == S_EXEC))
	// A blocked result keeps the beat in work and its addresses unchanged.
	`VRP_ASSERT(a_hold_while_blocked, (st_q == S_EXEC && rsp_valid_q && rsp_stall) |=> (st_q == S_EXEC && $stable(vram_addr_q) && $stable(sprite_addr_q)))
	// No memory write outside the update edge.
	`VRP_FORBID(a_no_stray_write, (vram_wr.nt_we || vram_wr.pal_we || vram_wr.pat_we || oam_we) && !exec_go)
	// A status read clears the shared write latch.
	`VRP_ASSERT(a_status_clears_latch, (exec_go && item_s1.command == vrp_pkg::CMD_READ && item_s1.register_select == vrp_pkg::REG_STATUS) |=> !second_q)

endmodule
